FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the quadrilateral scorer.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QRS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define QRS_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`else
`define QRS_ASSERT(label, prop)
`define QRS_ASSERT_MSG(label, prop, msg)
`endif
`endif

FILE: rtl/qrs_pkg.sv
// Package of the quadrilateral rectangle scorer: widths, latencies, tables.
// No dependencies; imported by every RTL module of the block.
`default_nettype none
package qrs_pkg;

    localparam int COORD_W    = 16;
    localparam int EDGE_W     = 17;
    localparam int PROD_W     = 34;
    localparam int CROSS_W    = 35;
    localparam int PAIR_W     = 36;
    localparam int NORM_W     = 41;
    localparam int NORM_TOP   = 40;
    localparam int SH_W       = 6;
    localparam int CORD_W     = 45;
    localparam int Z_W        = 20;
    localparam int CORD_STEPS = 16;
    localparam int ANG_W      = 18;

    localparam logic [ANG_W-1:0] ANG_PI      = 18'd205887;
    localparam logic [ANG_W-1:0] ANG_HALF_PI = 18'd102944;

    localparam int KPROD_W = 37;
    localparam int N_W     = 5;
    localparam int F_W     = 16;
    localparam int R_W     = 8;
    localparam int V_W     = 31;
    localparam int POW_W   = 30;
    localparam int POW_STEPS = 8;
    localparam int E_W     = 17;
    localparam logic [18:0] DECAY_K = 19'd270913;
    localparam logic [15:0] LN2_Q16 = 16'd45426;

    localparam int SUM_W    = 21;
    localparam int RECIP_W  = 24;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 24'd13421773;
    localparam int RECIP_SH = 27;
    localparam int Q_W      = 18;
    localparam int SCORE_W  = 16;

    localparam int ANG_LAT  = 5 + CORD_STEPS;
    localparam int DEC_LAT  = POW_STEPS + 4;
    localparam int CVX_LAT  = 3;
    localparam int PIPE_LAT = 2 + ANG_LAT + DEC_LAT + 3;
    localparam int CVX_DLY  = PIPE_LAT - 2 - CVX_LAT;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } pt_t;

    typedef struct packed {
        logic signed [EDGE_W-1:0] x;
        logic signed [EDGE_W-1:0] y;
    } vec_t;

    typedef logic [ANG_W-1:0] angle_t;
    typedef logic [E_W-1:0]   decay_t;

    // atan(2^-i) in Q16 radians
    function automatic logic signed [Z_W-1:0] atan_q16(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:  r = 20'sd51472;
            1:  r = 20'sd30386;
            2:  r = 20'sd16055;
            3:  r = 20'sd8150;
            4:  r = 20'sd4091;
            5:  r = 20'sd2047;
            6:  r = 20'sd1024;
            7:  r = 20'sd512;
            8:  r = 20'sd256;
            9:  r = 20'sd128;
            10: r = 20'sd64;
            11: r = 20'sd32;
            12: r = 20'sd16;
            13: r = 20'sd8;
            14: r = 20'sd4;
            15: r = 20'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // 2^(-2^-(j+1)) in Q30
    function automatic logic [POW_W-1:0] pow_q30(input int j);
        logic [POW_W-1:0] r;
        case (j)
            0: r = 30'd759250125;
            1: r = 30'd902905651;
            2: r = 30'd984625594;
            3: r = 30'd1028218693;
            4: r = 30'd1050733751;
            5: r = 30'd1062175491;
            6: r = 30'd1067942999;
            7: r = 30'd1070838486;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/qrs_convex.sv
// Convexity lane: sign agreement of the four corner cross products.
// Depends on qrs_pkg.
`default_nettype none
module qrs_convex
    import qrs_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  pt_t       pt [4],
    output logic      convex
);

    logic signed [PROD_W-1:0] pa_reg [4];
    logic signed [PROD_W-1:0] pb_reg [4];
    logic signed [1:0]        sg_reg [4];
    logic                     convex_reg;
    logic signed [1:0]        sg_next [4];
    logic                     convex_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pa_reg[i] <= (EDGE_W'(pt[(i+1)%4].x) - EDGE_W'(pt[i].x))
                           * (EDGE_W'(pt[(i+2)%4].y) - EDGE_W'(pt[(i+1)%4].y));
                pb_reg[i] <= (EDGE_W'(pt[(i+1)%4].y) - EDGE_W'(pt[i].y))
                           * (EDGE_W'(pt[(i+2)%4].x) - EDGE_W'(pt[(i+1)%4].x));
            end
            sg_reg     <= sg_next;
            convex_reg <= convex_next;
        end
    end

    always_comb
    begin
        logic signed [CROSS_W-1:0] c;
        for (int i = 0; i < 4; i++)
        begin
            c = CROSS_W'(pa_reg[i]) - CROSS_W'(pb_reg[i]);
            if (c == '0)
                sg_next[i] = 2'sd0;
            else if (c[CROSS_W-1])
                sg_next[i] = -2'sd1;
            else
                sg_next[i] = 2'sd1;
        end
    end

    // first nonzero sign sets the reference, later ones must match it
    always_comb
    begin
        logic signed [1:0] ref_sg;
        ref_sg      = 2'sd0;
        convex_next = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (ref_sg == 2'sd0)
                ref_sg = sg_reg[i];
            else if (sg_reg[i] != ref_sg)
                convex_next = 1'b0;
        end
    end

    assign convex = convex_reg;

endmodule
`default_nettype wire

FILE: rtl/qrs_angle.sv
// Angle lane: misalignment of two opposite edges via a pipelined CORDIC.
// Depends on qrs_pkg.
`default_nettype none
module qrs_angle
    import qrs_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  vec_t      a,
    input  vec_t      b,
    output angle_t    angle
);

    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [PAIR_W-1:0]        ymag_reg;
    logic signed [PAIR_W-1:0] xs_reg;
    logic [PAIR_W-1:0]        xn_reg, yn_reg;
    logic                     base0_reg, zero0_reg;

    logic signed [CORD_W-1:0] cx_reg [CORD_STEPS+1];
    logic signed [CORD_W-1:0] cy_reg [CORD_STEPS+1];
    logic signed [Z_W-1:0]    cz_reg [CORD_STEPS+1];
    logic                     cb_reg [CORD_STEPS+1];
    logic                     c0_reg [CORD_STEPS+1];
    angle_t                   angle_reg;

    logic [PAIR_W-1:0]        ymag_next;
    logic signed [PAIR_W-1:0] xs_next;
    logic [PAIR_W-1:0]        xn_next, yn_next;
    logic [NORM_W-1:0]        xm_next, ym_next;
    angle_t                   angle_next;

    // products, then cross and negated dot
    always_comb
    begin
        logic signed [CROSS_W-1:0] cr, dt;
        cr        = CROSS_W'(p0_reg) - CROSS_W'(p1_reg);
        dt        = CROSS_W'(p2_reg) + CROSS_W'(p3_reg);
        ymag_next = cr[CROSS_W-1] ? PAIR_W'(-cr) : PAIR_W'(cr);
        xs_next   = -PAIR_W'(dt);
    end

    // negative x: rotate by -pi/2
    always_comb
    begin
        if (xs_reg[PAIR_W-1])
        begin
            xn_next = ymag_reg;
            yn_next = PAIR_W'(-xs_reg);
        end
        else
        begin
            xn_next = PAIR_W'(xs_reg);
            yn_next = ymag_reg;
        end
    end

    // normalize so the larger operand lands in [2^40, 2^41)
    always_comb
    begin
        logic [PAIR_W-1:0] m;
        logic [SH_W-1:0]   msb;
        m   = (xn_reg > yn_reg) ? xn_reg : yn_reg;
        msb = '0;
        for (int i = 0; i < PAIR_W; i++)
            if (m[i])
                msb = SH_W'(i);
        xm_next = NORM_W'(xn_reg) << (SH_W'(NORM_TOP) - msb);
        ym_next = NORM_W'(yn_reg) << (SH_W'(NORM_TOP) - msb);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg    <= PROD_W'(a.x * b.y);
            p1_reg    <= PROD_W'(a.y * b.x);
            p2_reg    <= PROD_W'(a.x * b.x);
            p3_reg    <= PROD_W'(a.y * b.y);
            ymag_reg  <= ymag_next;
            xs_reg    <= xs_next;
            xn_reg    <= xn_next;
            yn_reg    <= yn_next;
            base0_reg <= xs_reg[PAIR_W-1];
            zero0_reg <= (xn_next == '0) && (yn_next == '0);
            cx_reg[0] <= CORD_W'(xm_next);
            cy_reg[0] <= CORD_W'(ym_next);
            cz_reg[0] <= '0;
            cb_reg[0] <= base0_reg;
            c0_reg[0] <= zero0_reg;
            angle_reg <= angle_next;
        end
    end

    // one CORDIC step per stage
    for (genvar k = 0; k < CORD_STEPS; k++)
    begin : g_step
        logic signed [CORD_W-1:0] cx_next, cy_next;
        logic signed [Z_W-1:0]    cz_next;

        always_comb
        begin
            if (!cy_reg[k][CORD_W-1])
            begin
                cx_next = cx_reg[k] + (cy_reg[k] >>> k);
                cy_next = cy_reg[k] - (cx_reg[k] >>> k);
                cz_next = cz_reg[k] + atan_q16(k);
            end
            else
            begin
                cx_next = cx_reg[k] - (cy_reg[k] >>> k);
                cy_next = cy_reg[k] + (cx_reg[k] >>> k);
                cz_next = cz_reg[k] - atan_q16(k);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[k+1] <= cx_next;
                cy_reg[k+1] <= cy_next;
                cz_reg[k+1] <= cz_next;
                cb_reg[k+1] <= cb_reg[k];
                c0_reg[k+1] <= c0_reg[k];
            end
        end
    end

    // clamp to [0, pi/2], add the quadrant, clamp to pi
    always_comb
    begin
        logic signed [Z_W-1:0] z;
        logic [ANG_W:0]        s;
        z = cz_reg[CORD_STEPS];
        if (z[Z_W-1])
            z = '0;
        else if (z > $signed({1'b0, ANG_HALF_PI}))
            z = Z_W'(ANG_HALF_PI);
        s = (ANG_W+1)'(z) + (cb_reg[CORD_STEPS] ? (ANG_W+1)'(ANG_HALF_PI) : '0);
        if (c0_reg[CORD_STEPS])
            angle_next = '0;
        else if (s > (ANG_W+1)'(ANG_PI))
            angle_next = ANG_PI;
        else
            angle_next = ANG_W'(s);
    end

    assign angle = angle_reg;

endmodule
`default_nettype wire

FILE: rtl/qrs_decay.sv
// Decay lane: exp(-d/0.349) in Q16 as a power of two, one multiply per stage.
// Depends on qrs_pkg.
`default_nettype none
module qrs_decay
    import qrs_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  angle_t    d,
    output decay_t    e
);

    logic [N_W-1:0]     n_reg [POW_STEPS+1];
    logic [F_W-1:0]     f_reg [POW_STEPS+1];
    logic [V_W-1:0]     v_reg [POW_STEPS+1];
    logic [V_W+R_W-1:0] vr_reg;
    logic [V_W-1:0]     va_reg, vb_reg;
    logic [N_W-1:0]     na_reg, nb_reg;
    decay_t             e_reg;

    logic [KPROD_W-1:0] u_prod;
    logic [V_W-1:0]     vb_next;

    assign u_prod = KPROD_W'(d) * KPROD_W'(DECAY_K);

    always_comb
    begin
        logic [V_W+R_W+16-1:0] t;
        t       = (V_W+R_W+16)'(vr_reg) * (V_W+R_W+16)'(LN2_Q16);
        vb_next = va_reg - V_W'(t >> 32);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= u_prod[KPROD_W-1:32];
            f_reg[0] <= u_prod[31:16];
            v_reg[0] <= V_W'(1) << 30;
            vr_reg   <= (V_W+R_W)'(v_reg[POW_STEPS]) * (V_W+R_W)'(f_reg[POW_STEPS][R_W-1:0]);
            va_reg   <= v_reg[POW_STEPS];
            na_reg   <= n_reg[POW_STEPS];
            vb_reg   <= vb_next;
            nb_reg   <= na_reg;
            e_reg    <= E_W'(vb_reg >> (7'(nb_reg) + 7'd14));
        end
    end

    // one fractional bit of the exponent per stage
    for (genvar j = 0; j < POW_STEPS; j++)
    begin : g_pow
        logic [V_W+POW_W-1:0] prod;
        logic [V_W-1:0]       v_next;

        always_comb
        begin
            prod   = (V_W+POW_W)'(v_reg[j]) * (V_W+POW_W)'(pow_q30(j));
            v_next = f_reg[j][F_W-1-j] ? V_W'(prod >> 30) : v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[j+1] <= v_next;
                n_reg[j+1] <= n_reg[j];
                f_reg[j+1] <= f_reg[j];
            end
        end
    end

    assign e = e_reg;

endmodule
`default_nettype wire

FILE: rtl/quad_rectangle_score_top.sv
// Throughput: one item per clock while the output is not stalled; the
// 16-step CORDIC and the 8-step power chain are fully pipelined, so
// nothing is shared between items.
// A stall on a valid output holds the whole pipeline and raises in_stall.
// Reset clears valid bits and sets min_score to 0.5 (32768); data regs
// are not reset.
`default_nettype none
`include "assert_macros.svh"
module quad_rectangle_score_top
    import qrs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [COORD_W-1:0] p0_x,
    input  wire logic signed [COORD_W-1:0] p0_y,
    input  wire logic signed [COORD_W-1:0] p1_x,
    input  wire logic signed [COORD_W-1:0] p1_y,
    input  wire logic signed [COORD_W-1:0] p2_x,
    input  wire logic signed [COORD_W-1:0] p2_y,
    input  wire logic signed [COORD_W-1:0] p3_x,
    input  wire logic signed [COORD_W-1:0] p3_y,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           convex,
    output logic [SCORE_W-1:0]             score,
    output logic                           accept,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [SCORE_W-1:0]        cfg_data
);

    logic                 adv;
    logic [PIPE_LAT-1:0]  vld_reg, vld_next;
    logic [SCORE_W-1:0]   min_score_reg;

    pt_t                  pt_reg [4];
    vec_t                 edge_reg [4];
    angle_t               d0, d1, dmin, dmax;
    decay_t               emin, emax;
    logic                 cvx_lane;
    logic                 cvx_reg [CVX_DLY];
    logic [SUM_W-1:0]     sum_reg;
    logic [Q_W-1:0]       q_reg;
    logic                 convex_reg, accept_reg;
    logic [SCORE_W-1:0]   score_reg;
    logic [SUM_W+RECIP_W-1:0] q_prod;
    logic [SCORE_W-1:0]   score_next;

    // the whole pipeline advances unless a finished result is held back
    assign adv       = !(vld_reg[PIPE_LAT-1] && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;
    assign vld_next  = {vld_reg[PIPE_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            min_score_reg <= SCORE_W'(32768);
        end
        else
        begin
            if (adv)
                vld_reg <= vld_next;
            if (cfg_valid && cfg_ready)
                min_score_reg <= cfg_data;
        end
    end

    // capture the corners and form the edges, a zero edge points along +x
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_reg[0] <= '{x: p0_x, y: p0_y};
            pt_reg[1] <= '{x: p1_x, y: p1_y};
            pt_reg[2] <= '{x: p2_x, y: p2_y};
            pt_reg[3] <= '{x: p3_x, y: p3_y};
            for (int i = 0; i < 4; i++)
            begin
                if ((pt_reg[i].x == pt_reg[(i+1)%4].x)
                    && (pt_reg[i].y == pt_reg[(i+1)%4].y))
                    edge_reg[i].x <= EDGE_W'(1);
                else
                    edge_reg[i].x <= EDGE_W'(pt_reg[i].x) - EDGE_W'(pt_reg[(i+1)%4].x);
                edge_reg[i].y <= EDGE_W'(pt_reg[i].y) - EDGE_W'(pt_reg[(i+1)%4].y);
            end
        end
    end

    // one angle lane per pair of opposite edges
    qrs_angle u_ang0 (.clk(clk), .en(adv), .a(edge_reg[0]), .b(edge_reg[2]), .angle(d0));
    qrs_angle u_ang1 (.clk(clk), .en(adv), .a(edge_reg[1]), .b(edge_reg[3]), .angle(d1));

    // order the two misalignments before the decay lanes
    assign dmin = (d0 < d1) ? d0 : d1;
    assign dmax = (d0 < d1) ? d1 : d0;

    qrs_decay u_dec0 (.clk(clk), .en(adv), .d(dmin), .e(emin));
    qrs_decay u_dec1 (.clk(clk), .en(adv), .d(dmax), .e(emax));

    qrs_convex u_cvx (.clk(clk), .en(adv), .pt(pt_reg), .convex(cvx_lane));

    // merge: weighted sum, divide by ten through a reciprocal, saturate
    assign q_prod     = (SUM_W+RECIP_W)'(sum_reg) * (SUM_W+RECIP_W)'(RECIP_TEN);
    assign score_next = (q_reg > Q_W'(65535)) ? '1 : SCORE_W'(q_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cvx_reg[0] <= cvx_lane;
            for (int i = 1; i < CVX_DLY; i++)
                cvx_reg[i] <= cvx_reg[i-1];
            sum_reg    <= SUM_W'(emin) * SUM_W'(9) + SUM_W'(emax) + SUM_W'(5);
            q_reg      <= Q_W'(q_prod >> RECIP_SH);
            convex_reg <= cvx_reg[CVX_DLY-1];
            score_reg  <= score_next;
            accept_reg <= cvx_reg[CVX_DLY-1] && (score_next > min_score_reg);
        end
    end

    assign out_valid = vld_reg[PIPE_LAT-1];
    assign convex    = convex_reg;
    assign score     = score_reg;
    assign accept    = accept_reg;

    `QRS_ASSERT(a_accept_needs_convex, out_valid && accept |-> convex)
    `QRS_ASSERT(a_accept_over_threshold, out_valid && accept |-> score > min_score_reg)
    `QRS_ASSERT_MSG(a_stall_link, in_stall == (out_valid && out_stall), "stall mismatch")
    `QRS_ASSERT_MSG(a_pipe_fill, adv && vld_reg[PIPE_LAT-2] |=> out_valid, "lost item")

endmodule
`default_nettype wire
